/* design/rlid_pkg.sv */
`default_nettype none
package rlid_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CAP_W     = 2 * DIM_W + 2;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int HDR_BYTES = 8;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DIM      = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [2:0] MODE_RGB  = 3'd3;
  localparam logic [2:0] MODE_GREY = 3'd4;
  localparam logic [1:0] LANE_ALL  = 2'd3;

  localparam logic [0:0] REG_LEVELS = 1'b0;
  localparam logic [0:0] REG_MODE   = 1'b1;

  localparam logic [1:0] PHASE_VALUE = 2'd0;
  localparam logic [1:0] PHASE_HIGH  = 2'd1;
  localparam logic [1:0] PHASE_LOW   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  sample_value;
    logic [15:0] run_length;
    logic [25:0] start_index;
    logic [1:0]  start_lane;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_BYTE,
    ST_CAP,
    ST_CAP3,
    ST_DIV,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic cap_mul;
    logic cap_tri;
    logic div_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic run_ok;
    logic err;
    logic out_free;
  } dp_sts_t;

  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage
`default_nettype wire

/* design/rlid_ctrl.sv */
`default_nettype none
module rlid_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  rlid_pkg::dp_sts_t  sts,
  output rlid_pkg::dp_cmd_t  cmd
);
  import rlid_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 take;

  assign take = in_valid && (state_r == ST_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BYTE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_BYTE: begin
        if (take && sts.hdr_ok) begin
          state_nxt = ST_CAP;
        end else if (take && sts.run_ok) begin
          state_nxt = ST_DIV;
          cnt_nxt   = DIV_CNT_W'(DIV_STEPS - 1);
        end else if (take && sts.err) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_CAP:  state_nxt = ST_CAP3;
      ST_CAP3: state_nxt = ST_LOAD;
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = ST_BYTE;
        end
      end
      default: state_nxt = ST_BYTE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_BYTE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_CAP:  cmd.cap_mul  = 1'b1;
      ST_CAP3: cmd.cap_tri  = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LOAD: cmd.load     = sts.out_free;
      default: in_stall = 1'b1;
    endcase
  end

`ifndef SYNTH
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_LOAD))
    else $error("divider did not hand over to load");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (take && sts.run_ok) |=> ##8 (state_r == ST_LOAD))
    else $error("run record not ready after divide");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_BYTE) |-> in_stall)
    else $error("input taken while busy");
`endif

endmodule
`default_nettype wire

/* design/rlid_dp.sv */
`default_nettype none
module rlid_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rlid_pkg::in_item_t   in_data,
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_index,
  input  wire  [8:0]           cfg_wdata,
  input  rlid_pkg::dp_cmd_t    cmd,
  output rlid_pkg::dp_sts_t    sts,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rlid_pkg::out_item_t  out_data
);
  import rlid_pkg::*;

  logic [8:0]       levels_r;
  logic [2:0]       mode_r;

  logic [3:0]       hcnt_r, hcnt_nxt;
  logic [63:0]      shift_r, shift_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       held_val_r, held_val_nxt;
  logic [7:0]       held_hi_r, held_hi_nxt;
  logic [CAP_W-1:0] pos_r, pos_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [1:0]       lane_r, lane_nxt;
  logic             stopped_r, stopped_nxt;
  logic [2:0]       fmode_r;

  logic [1:0]       pend_kind_r, pend_kind_nxt;
  logic [1:0]       pend_err_r, pend_err_nxt;
  logic [15:0]      pend_cnt_r;
  logic [CAP_W-1:0] pend_idx_r;
  logic [1:0]       pend_lane_r, pend_lane_nxt;
  logic             sat_r;

  logic [8:0]       div_d_r;
  logic [8:0]       div_rem_r;
  logic [7:0]       div_num_r;

  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic             start;
  logic             stop_e;
  logic [3:0]       hcnt_e;
  logic [63:0]      shift_e;
  logic [1:0]       phase_e;
  logic [CAP_W-1:0] pos_e;
  logic [CAP_W-1:0] cap_e;
  logic [1:0]       lane_e;
  logic [31:0]      dim_w, dim_h;
  logic             w_ok, h_ok;
  logic [15:0]      count;
  logic [CAP_W:0]   run_end;
  logic [2:0]       lane_sum;
  logic [2:0]       mode_clamp;
  logic [8:0]       lv;
  logic             sat_nxt;
  logic [15:0]      numer;
  logic [9:0]       div_t;
  logic             div_ge;
  logic [9:0]       div_diff;

  assign start  = in_data.frame_start;
  assign stop_e = start ? 1'b0 : stopped_r;
  assign hcnt_e = start ? '0 : hcnt_r;
  assign shift_e = start ? '0 : shift_r;
  assign phase_e = start ? PHASE_VALUE : phase_r;
  assign pos_e  = start ? '0 : pos_r;
  assign cap_e  = start ? '0 : cap_r;
  assign lane_e = start ? '0 : lane_r;

  assign dim_w = shift_e[55:24];
  assign dim_h = {shift_e[23:0], in_data.data_byte};
  assign w_ok  = (dim_w != '0) && !dim_w[31] && (dim_w <= 32'(MAX_DIM));
  assign h_ok  = (dim_h != '0) && !dim_h[31] && (dim_h <= 32'(MAX_DIM));
  assign count = {held_hi_r, in_data.data_byte};
  assign run_end = {1'b0, pos_e} + (CAP_W+1)'(count);
  assign lane_sum = 3'(lane_e) + 3'(mod3_16(count));
  assign mode_clamp = (mode_r > MODE_GREY) ? MODE_GREY : mode_r;
  assign lv = (levels_r < 9'd2) ? 9'd2 : levels_r;
  assign sat_nxt = {1'b0, held_val_r} >= lv;
  assign numer = {held_val_r, 8'h00} - 16'(held_val_r);

  always_comb begin
    hcnt_nxt      = hcnt_e;
    shift_nxt     = shift_e;
    phase_nxt     = phase_e;
    held_val_nxt  = start ? '0 : held_val_r;
    held_hi_nxt   = start ? '0 : held_hi_r;
    pos_nxt       = pos_e;
    lane_nxt      = lane_e;
    stopped_nxt   = stop_e;
    pend_kind_nxt = KIND_RUN;
    pend_err_nxt  = ERR_NONE;
    pend_lane_nxt = LANE_ALL;
    sts.hdr_ok    = 1'b0;
    sts.run_ok    = 1'b0;
    sts.err       = 1'b0;
    sts.out_free  = !out_valid_r || !out_stall;
    if (!stop_e) begin
      if (hcnt_e < 4'(HDR_BYTES)) begin
        shift_nxt = {shift_e[55:0], in_data.data_byte};
        hcnt_nxt  = hcnt_e + 1'b1;
        if (hcnt_e == 4'(HDR_BYTES - 1)) begin
          if (w_ok && h_ok) begin
            sts.hdr_ok    = 1'b1;
            pend_kind_nxt = KIND_HEADER;
          end else begin
            sts.err       = 1'b1;
            stopped_nxt   = 1'b1;
            pend_kind_nxt = KIND_ERROR;
            pend_err_nxt  = ERR_DIM;
          end
        end
      end else begin
        case (phase_e)
          PHASE_VALUE: begin
            held_val_nxt = in_data.data_byte;
            phase_nxt    = PHASE_HIGH;
          end
          PHASE_HIGH: begin
            held_hi_nxt = in_data.data_byte;
            phase_nxt   = PHASE_LOW;
          end
          default: begin
            phase_nxt = PHASE_VALUE;
            if (count != '0) begin
              if (run_end > {1'b0, cap_e}) begin
                sts.err       = 1'b1;
                stopped_nxt   = 1'b1;
                pend_kind_nxt = KIND_ERROR;
                pend_err_nxt  = ERR_OVERFLOW;
              end else begin
                sts.run_ok = 1'b1;
                pos_nxt    = run_end[CAP_W-1:0];
                lane_nxt   = (lane_sum >= 3'd3) ? 2'(lane_sum - 3'd3) : lane_sum[1:0];
                if (fmode_r == MODE_RGB) begin
                  pend_lane_nxt = lane_e;
                end else if (fmode_r == MODE_GREY) begin
                  pend_lane_nxt = LANE_ALL;
                end else begin
                  pend_lane_nxt = fmode_r[1:0];
                end
              end
            end
          end
        endcase
      end
    end
  end

  assign div_t    = {div_rem_r, div_num_r[7]};
  assign div_ge   = div_t >= {1'b0, div_d_r};
  assign div_diff = div_t - {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= 9'd16;
      mode_r   <= MODE_GREY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVELS: levels_r <= cfg_wdata;
        REG_MODE:   mode_r   <= cfg_wdata[2:0];
        default:    levels_r <= levels_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r     <= '0;
      shift_r    <= '0;
      phase_r    <= PHASE_VALUE;
      held_val_r <= '0;
      held_hi_r  <= '0;
      pos_r      <= '0;
      cap_r      <= '0;
      lane_r     <= '0;
      stopped_r  <= 1'b1;
      fmode_r    <= MODE_GREY;
    end else if (cmd.take) begin
      hcnt_r     <= hcnt_nxt;
      shift_r    <= shift_nxt;
      phase_r    <= phase_nxt;
      held_val_r <= held_val_nxt;
      held_hi_r  <= held_hi_nxt;
      pos_r      <= pos_nxt;
      cap_r      <= cap_e;
      lane_r     <= lane_nxt;
      stopped_r  <= stopped_nxt;
      if (sts.hdr_ok) begin
        fmode_r <= mode_clamp;
      end
    end else if (cmd.cap_mul) begin
      cap_r <= CAP_W'(shift_r[32 +: DIM_W]) * CAP_W'(shift_r[0 +: DIM_W]);
    end else if (cmd.cap_tri) begin
      if (fmode_r == MODE_RGB) begin
        cap_r <= cap_r + {cap_r[CAP_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_kind_r <= pend_kind_nxt;
      pend_err_r  <= pend_err_nxt;
      pend_cnt_r  <= count;
      pend_idx_r  <= pos_e;
      pend_lane_r <= pend_lane_nxt;
      sat_r       <= sat_nxt;
      div_d_r     <= lv - 9'd1;
      div_rem_r   <= {1'b0, numer[15:8]};
      div_num_r   <= numer[7:0];
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_diff[8:0] : div_t[8:0];
      div_num_r <= {div_num_r[6:0], div_ge};
    end
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.result_kind = pend_kind_r;
    case (pend_kind_r)
      KIND_HEADER: begin
        out_nxt.image_width  = shift_r[44:32];
        out_nxt.image_height = shift_r[12:0];
      end
      KIND_RUN: begin
        out_nxt.sample_value = sat_r ? 8'hFF : div_num_r;
        out_nxt.run_length   = pend_cnt_r;
        out_nxt.start_index  = pend_idx_r[25:0];
        out_nxt.start_lane   = pend_lane_r;
      end
      default: out_nxt.error_code = pend_err_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transaction");
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cap_r)
    else $error("element position past capacity");
  a_hdr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.hdr_ok) |=> !stopped_r)
    else $error("frame stopped after good header");
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({sts.hdr_ok, sts.run_ok, sts.err}))
    else $error("conflicting byte outcomes");
`endif

endmodule
`default_nettype wire

/* design/rle_level_image_decoder.sv */
`default_nettype none
// Run-length image decoder with level expansion. One payload byte is taken per
// cycle while no result is being prepared; bytes that produce no result (header
// bytes before the last, the first two bytes of a triplet, zero-length runs,
// bytes while stopped) never stall. The last header byte stalls input through
// capacity multiply, rgb scaling and result load; the last byte of a non-empty
// run stalls it while the 8-step restoring divider scales the sample by
// 255/(levels-1) and the result is loaded; an error result goes straight to
// the result load. Each result waits in the output register until taken, and
// a further result is loaded only once the previous one has left. A byte with
// frame_start begins a new frame; after reset or an error, other bytes are
// dropped. levels is read when a run completes, channel_mode when the header
// completes. The user must write configuration only while idle; not enforced.
module rle_level_image_decoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  rlid_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rlid_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_index,
  input  wire  [8:0]           cfg_wdata
);
  import rlid_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rlid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
